// ===== rtl/bms_pkg.sv =====
// bms_pkg: shared widths and controller/datapath interface types for the
// bin mean smoother; no dependencies
package bms_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int DEPTH_W  = 7;
  localparam int VALUE_W  = 24;
  localparam int FRAC_W   = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // reset value of the bin depth register
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 7'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic load;    // latch sum and count into the divider, clear the bin
    logic step;    // one restoring division step
    logic pop;     // output transaction taken this cycle
  } bms_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic close;     // offered sample closes the bin
    logic div_last;  // current division step is the final one
    logic run_last;  // result on the output is the last of its run
  } bms_sts_t;

endpackage

// ===== rtl/bms_dpath.sv =====
// bms_dpath: bin accumulator, serial restoring divider and result counter
// depends on bms_pkg
module bms_dpath #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bms_pkg::bms_cmd_t              cmd_i,
  output bms_pkg::bms_sts_t              sts_o,
  input  logic [bms_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           last_sample_i,
  input  logic [bms_pkg::DEPTH_W-1:0]    depth_i,
  output logic [bms_pkg::VALUE_W-1:0]    value_o,
  output logic                           last_of_run_o
);

  localparam int SmpW  = bms_pkg::SAMPLE_W;
  localparam int DepW  = bms_pkg::DEPTH_W;
  localparam int ValW  = bms_pkg::VALUE_W;
  localparam int FracW = bms_pkg::FRAC_W;
  localparam int CntW  = $clog2(MAX_DEPTH + 1);
  localparam int SumW  = SmpW + $clog2(MAX_DEPTH);
  localparam int DivW  = SumW + FracW;
  localparam int ItW   = $clog2(DivW);

  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_new;
  logic [DivW-1:0] quo_q, quo_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] left_q, left_d;
  logic [ItW-1:0]  it_q, it_d;
  logic [DepW-1:0] eff_depth;
  logic [CntW:0]   rem_sh;
  logic [CntW:0]   rem_sub;
  logic            ge;

  // depth zero acts as one, large depths saturate
  always_comb begin
    eff_depth = depth_i;
    if (depth_i == '0) begin
      eff_depth = DepW'(1);
    end else if (depth_i > DepW'(MAX_DEPTH)) begin
      eff_depth = DepW'(MAX_DEPTH);
    end
  end

  assign cnt_new = cnt_q + CntW'(1);

  // bin closes when full or flushed by the last sample
  assign sts_o.close    = last_sample_i || (DepW'(cnt_new) >= eff_depth);
  assign sts_o.div_last = (it_q == ItW'(DivW - 1));
  assign sts_o.run_last = (left_q == CntW'(1));

  // one restoring division step
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    left_d = left_q;
    it_d   = it_q;
    // accumulate the offered sample
    if (cmd_i.accept) begin
      sum_d = sum_q + SumW'(sample_i);
      cnt_d = cnt_new;
    end
    // move the closed bin into the divider
    if (cmd_i.load) begin
      quo_d  = {sum_q, {FracW{1'b0}}};
      rem_d  = '0;
      dvs_d  = cnt_q;
      left_d = cnt_q;
      it_d   = '0;
      sum_d  = '0;
      cnt_d  = '0;
    end
    if (cmd_i.step) begin
      quo_d = {quo_q[DivW-2:0], ge};
      rem_d = ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      it_d  = it_q + ItW'(1);
    end
    // count down the copies of the mean
    if (cmd_i.pop) begin
      left_d = left_q - CntW'(1);
    end
  end

  // bin state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      left_q <= '0;
      it_q   <= '0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      left_q <= left_d;
      it_q   <= it_d;
    end
  end

  // divider payload
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign value_o       = ValW'(quo_q);
  assign last_of_run_o = sts_o.run_last;

endmodule

// ===== rtl/bms_ctrl.sv =====
// bms_ctrl: sequencer for accumulate, divide and emit phases
// depends on bms_pkg
module bms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bms_pkg::bms_sts_t sts_i,
  output bms_pkg::bms_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);

  // commands
  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == StIdle);
    cmd_o.load   = (state_q == StLoad);
    cmd_o.step   = (state_q == StDiv);
    cmd_o.pop    = out_ready_i && (state_q == StEmit);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && sts_i.close) state_d = StLoad;
      end
      StLoad: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (sts_i.div_last) state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i && sts_i.run_last) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bin_mean_smoother.sv =====
// bin_mean_smoother: top level with the depth register and APB port
// depends on bms_pkg, bms_ctrl and bms_dpath
//
// Input stream (s_axis_*): one unsigned sample per transaction, tlast
// marks the final sample of a stream and flushes a partial bin.
// Output stream (m_axis_*): the 16.8 mean of each closed bin, repeated
// once per sample of that bin; tlast marks the last copy.
// The APB register bin_depth (address 0) sets the samples per bin; zero
// acts as one and values above MAX_DEPTH saturate. Write it while idle.
// Sequence: a sample that does not close its bin is accumulated and the
// input stays ready. A closing sample is followed by a load step and
// 8 + SUM_W division steps (30 at MAX_DEPTH = 64) of the one-bit-per-cycle
// restoring divider; then the N copies come out, one per cycle while
// m_axis_tready is high. No sample is taken while a bin is loading,
// dividing or emitting; a stalled receiver holds the current copy and
// the block.
// Reset empties the open bin and loads bin_depth with 3.
module bin_mean_smoother #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
  input  logic                          s_axis_tlast,   // last_sample
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [23:0] smoothed_value
  output logic                          m_axis_tlast,   // last_of_run
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bms_pkg::APB_AW-1:0]    paddr,
  input  logic [bms_pkg::APB_DW-1:0]    pwdata,
  output logic [bms_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int DepW = bms_pkg::DEPTH_W;
  localparam int DatW = bms_pkg::APB_DW;

  logic [DepW-1:0]   depth_q;
  logic              depth_sel;
  bms_pkg::bms_cmd_t cmd;
  bms_pkg::bms_sts_t sts;

  // register decode, word address zero
  assign pready    = 1'b1;
  assign depth_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= bms_pkg::DEPTH_RST;
    end else if (psel && penable && pwrite && depth_sel) begin
      depth_q <= pwdata[DepW-1:0];
    end
  end

  assign prdata = depth_sel ? DatW'(depth_q) : '0;

  // sequencer
  bms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // accumulator and divider
  bms_dpath #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (s_axis_tdata),
    .last_sample_i(s_axis_tlast),
    .depth_i      (depth_q),
    .value_o      (m_axis_tdata),
    .last_of_run_o(m_axis_tlast)
  );

endmodule
